// File: sv/a12m_pkg.sv
`timescale 1ns / 1ps

package a12m_pkg;

  // item opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_PPU   = 2'd2;

  // configuration register indexes (paddr[2])
  localparam logic REG_FILTER = 1'b0;
  localparam logic REG_HDR    = 1'b1;

  localparam int unsigned PADDR_W = 3;

  // CPU register write decode
  localparam logic [13:0] ADDR_PRG_HI   = 14'h2000; // 8000-8003 >> 2
  localparam logic [12:0] ADDR_CHR_HI   = 13'h1400; // A000-A007 >> 3
  localparam logic [15:0] ADDR_RELOAD   = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_ACK  = 16'hC002;
  localparam logic [15:0] ADDR_ARM      = 16'hC003;
  localparam logic [15:0] ADDR_MIRROR   = 16'hD000;
  localparam logic [15:0] ADDR_IRQ_EN   = 16'hE000;

  // PRG reset banks: the last four pages
  localparam logic [7:0] PRG_RESET_BASE = 8'hFC;
  localparam logic [3:0] FILTER_RESET   = 4'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] address;
    logic [7:0]  data;
    logic [31:0] cpu_cycle;
  } item_t;

  typedef struct packed {
    logic [3:0] a12_filter_cycles;
    logic       hdr_mirror;
    logic       hdr_wr;
  } cfg_t;

  typedef struct packed {
    logic       irq_active;
    logic       mirror_horizontal;
    logic [7:0] bank;
    logic       bank_valid;
  } result_t;

endpackage

// File: sv/a12m_cfg.sv
`timescale 1ns / 1ps

module a12m_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [a12m_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output a12m_pkg::cfg_t                   cfg
);

  logic [3:0] a12_filter_cycles;
  logic       hdr_mirror;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      a12_filter_cycles <= a12m_pkg::FILTER_RESET;
      hdr_mirror        <= 1'b0;
    end else if (wr_en) begin
      if (paddr[2] == a12m_pkg::REG_FILTER) begin
        a12_filter_cycles <= pwdata[3:0];
      end else begin
        hdr_mirror <= pwdata[0];
      end
    end
  end

  // read mux
  always_comb begin
    if (paddr[2] == a12m_pkg::REG_FILTER) begin
      prdata = {28'd0, a12_filter_cycles};
    end else begin
      prdata = {31'd0, hdr_mirror};
    end
  end

  // header write also reloads the live mirroring flag in the core
  assign cfg.a12_filter_cycles = a12_filter_cycles;
  assign cfg.hdr_mirror        = pwdata[0];
  assign cfg.hdr_wr            = wr_en && (paddr[2] == a12m_pkg::REG_HDR);

endmodule

// File: sv/a12m_in_reg.sv
`timescale 1ns / 1ps

module a12m_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  a12m_pkg::item_t in_item,
  output logic            full,
  output a12m_pkg::item_t item,
  input  logic            advance
);

  // hold the item while the core cannot take it
  assign in_stall = full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!in_stall) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item <= in_item;
    end
  end

endmodule

// File: sv/a12m_core.sv
`timescale 1ns / 1ps

module a12m_core (
  input  logic              clk,
  input  logic              rst,
  input  a12m_pkg::cfg_t    cfg,
  input  a12m_pkg::item_t   item,
  input  logic              advance,
  output a12m_pkg::result_t result
);

  logic [7:0]  prg_bank_regs [4];
  logic [7:0]  chr_bank_regs [8];
  logic        mirroring_flag;
  logic [7:0]  irq_reload;
  logic [7:0]  irq_count;
  logic        irq_enable;
  logic        irq_armed;
  logic        irq_line;
  logic        a12_low_seen;
  logic [31:0] a12_low_start;

  logic [7:0]  prg_bank_regs_next [4];
  logic [7:0]  chr_bank_regs_next [8];
  logic        mirroring_flag_next;
  logic [7:0]  irq_reload_next;
  logic [7:0]  irq_count_next;
  logic        irq_enable_next;
  logic        irq_armed_next;
  logic        irq_line_next;
  logic        a12_low_seen_next;
  logic [31:0] a12_low_start_next;

  logic [31:0] low_time;
  logic        rise;
  logic [7:0]  bank_sel;
  logic        bank_hit;

  assign low_time = item.cpu_cycle - a12_low_start;

  // register writes, A12 filter and scanline counter
  always_comb begin
    prg_bank_regs_next  = prg_bank_regs;
    chr_bank_regs_next  = chr_bank_regs;
    mirroring_flag_next = mirroring_flag;
    irq_reload_next     = irq_reload;
    irq_count_next      = irq_count;
    irq_enable_next     = irq_enable;
    irq_armed_next      = irq_armed;
    irq_line_next       = irq_line;
    a12_low_seen_next   = a12_low_seen;
    a12_low_start_next  = a12_low_start;
    rise                = 1'b0;
    bank_sel            = 8'd0;
    bank_hit            = 1'b0;
    case (item.op)
      a12m_pkg::OP_WRITE: begin
        if (item.address[15:2] == a12m_pkg::ADDR_PRG_HI) begin
          prg_bank_regs_next[item.address[1:0]] = item.data;
        end else if (item.address[15:3] == a12m_pkg::ADDR_CHR_HI) begin
          chr_bank_regs_next[item.address[2:0]] = item.data;
        end else if (item.address == a12m_pkg::ADDR_RELOAD) begin
          irq_reload_next = item.data;
        end else if (item.address == a12m_pkg::ADDR_IRQ_ACK) begin
          irq_line_next = 1'b0;
        end else if (item.address == a12m_pkg::ADDR_ARM) begin
          irq_count_next = irq_reload;
          irq_armed_next = 1'b1;
        end else if (item.address == a12m_pkg::ADDR_MIRROR) begin
          mirroring_flag_next = item.data[0];
        end else if (item.address == a12m_pkg::ADDR_IRQ_EN) begin
          irq_enable_next = item.data[0];
          irq_line_next   = 1'b0;
        end
      end
      a12m_pkg::OP_READ: begin
        if (item.address[15]) begin
          bank_sel = prg_bank_regs[item.address[14:13]];
          bank_hit = 1'b1;
        end
      end
      a12m_pkg::OP_PPU: begin
        if (item.address[12]) begin
          rise = a12_low_seen && (low_time >= {28'd0, cfg.a12_filter_cycles});
          a12_low_seen_next = 1'b0;
        end else if (!a12_low_seen) begin
          a12_low_seen_next  = 1'b1;
          a12_low_start_next = item.cpu_cycle;
        end
        if (rise && irq_enable && irq_armed && (irq_count != 8'd0)) begin
          irq_count_next = irq_count - 8'd1;
          if (irq_count == 8'd1) begin
            irq_line_next  = 1'b1;
            irq_armed_next = 1'b0;
          end
        end
        if (item.address[15:13] == 3'd0) begin
          bank_sel = chr_bank_regs[item.address[12:10]];
          bank_hit = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        prg_bank_regs[i] <= a12m_pkg::PRG_RESET_BASE + 8'(i);
      end
      for (int i = 0; i < 8; i++) begin
        chr_bank_regs[i] <= 8'd0;
      end
      mirroring_flag <= 1'b0;
      irq_reload     <= 8'd0;
      irq_count      <= 8'd0;
      irq_enable     <= 1'b0;
      irq_armed      <= 1'b0;
      irq_line       <= 1'b0;
      a12_low_seen   <= 1'b0;
      a12_low_start  <= 32'd0;
    end else if (cfg.hdr_wr) begin
      mirroring_flag <= cfg.hdr_mirror;
    end else if (advance) begin
      prg_bank_regs  <= prg_bank_regs_next;
      chr_bank_regs  <= chr_bank_regs_next;
      mirroring_flag <= mirroring_flag_next;
      irq_reload     <= irq_reload_next;
      irq_count      <= irq_count_next;
      irq_enable     <= irq_enable_next;
      irq_armed      <= irq_armed_next;
      irq_line       <= irq_line_next;
      a12_low_seen   <= a12_low_seen_next;
      a12_low_start  <= a12_low_start_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      result.irq_active        <= irq_line_next;
      result.mirror_horizontal <= mirroring_flag_next;
      result.bank              <= bank_sel;
      result.bank_valid        <= bank_hit;
    end
  end

endmodule

// File: sv/bank_switch_a12_irq_mapper.sv
`timescale 1ns / 1ps

// Cartridge mapper with PRG/CHR bank registers and a filtered PPU A12 scanline
// IRQ counter. Each item (CPU register write, CPU read address or PPU address)
// yields one result with the IRQ level, the mirroring and the selected bank.
// An item is held in an input register and then processed into the result
// register; one item is taken every cycle, limited only by the result register
// being held by out_stall. Configuration (APB, registers at 0x0 and 0x4) is to
// be written only while the block is idle, which the user must keep to; the
// block itself does not enforce it. A write to the header mirroring register
// also reloads the live mirroring flag.
module bank_switch_a12_irq_mapper (
  input  logic                         clk,
  input  logic                         rst,
  // item channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   op,
  input  logic [15:0]                  address,
  input  logic [7:0]                   data,
  input  logic [31:0]                  cpu_cycle,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         irq_active,
  output logic                         mirror_horizontal,
  output logic [7:0]                   bank,
  output logic                         bank_valid,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [a12m_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  a12m_pkg::cfg_t    cfg;
  a12m_pkg::item_t   in_item;
  a12m_pkg::item_t   item;
  a12m_pkg::result_t result;
  logic              full;
  logic              advance;

  assign in_item.op        = op;
  assign in_item.address   = address;
  assign in_item.data      = data;
  assign in_item.cpu_cycle = cpu_cycle;

  // move the held item into the result register when that slot frees up
  assign advance = full && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a12m_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  a12m_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .full     (full),
    .item     (item),
    .advance  (advance)
  );

  a12m_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (item),
    .advance (advance),
    .result  (result)
  );

  assign irq_active        = result.irq_active;
  assign mirror_horizontal = result.mirror_horizontal;
  assign bank              = result.bank;
  assign bank_valid        = result.bank_valid;

endmodule

// File: sv/a12m_checker.sv
`timescale 1ns / 1ps

module a12m_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       irq_active,
  input logic       mirror_horizontal,
  input logic [7:0] bank,
  input logic       bank_valid,
  input logic       pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bank) && $stable(bank_valid)
      && $stable(irq_active) && $stable(mirror_horizontal))
    else $error("stalled result changed");

  // no bank value leaks out when the address selects none
  a_bank_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bank_valid |-> bank == 8'd0)
    else $error("bank nonzero without bank_valid");

  // input only backs up behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // config port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind bank_switch_a12_irq_mapper a12m_checker u_a12m_checker (
  .clk               (clk),
  .rst               (rst),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .irq_active        (irq_active),
  .mirror_horizontal (mirror_horizontal),
  .bank              (bank),
  .bank_valid        (bank_valid),
  .pready            (pready)
);
